// ----- design/synchro_phase_to_angle_filter_macros.svh -----
// assertion macros for the synchro phase-to-angle filter
// expects clk and arst_n in the scope of use
`ifndef SYNCHRO_PHASE_TO_ANGLE_FILTER_MACROS_SVH
`define SYNCHRO_PHASE_TO_ANGLE_FILTER_MACROS_SVH

// same-cycle implication
`define SPAF_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPAF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/spaf_pkg.sv -----
// shared types, constants and helpers of the synchro phase-to-angle filter
// no dependencies
`default_nettype none

package spaf_pkg;

	localparam int FULL_TURN = 32768;
	localparam int CHANNELS  = 2;

	localparam logic [15:0] TURN16    = 16'(FULL_TURN);
	localparam logic [15:0] HALF_TURN = 16'(FULL_TURN / 2);
	localparam logic [15:0] ONE_DEG   = 16'(FULL_TURN / 360);

	// magnitude of phase << 15 and restoring divider step count
	localparam int NUM_W     = 31;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_INTERVAL_MIN  = 3'd0,
		REG_INTERVAL_MAX  = 3'd1,
		REG_FILTER_SHIFT  = 3'd2,
		REG_GAIN_MAIN     = 3'd3,
		REG_GAIN_POSITIVE = 3'd4,
		REG_GAIN_NEGATIVE = 3'd5,
		REG_AZIMUTH_MODE  = 3'd6,
		REG_ZERO_CAL_EN   = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_CAL,
		ST_CAL_SUB,
		ST_WRAP,
		ST_FILTER,
		ST_GAIN_MAIN,
		ST_GAIN_POL,
		ST_GAIN_SEL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	// wrap once into plus/minus half a turn
	function automatic logic [15:0] wrap_half(input logic [15:0] v);
		logic [15:0] nv;
		logic [15:0] r;
		nv = 16'd0 - v;
		r  = v;
		if (v[15]) begin
			if (nv > HALF_TURN) r = v + TURN16;
		end else if (v > HALF_TURN) begin
			r = v - TURN16;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/synchro_phase_to_angle_filter.sv -----
// synchro phase-to-angle filter: sequencer, channel state, apb registers
// a rejected beat goes from check straight to done; zero cal adds one state
// the 31-step restoring divider runs for accepted beats with a nonzero period; one item in flight at a time
// the input is ready again only after the result register takes the result
// reset: arst_n clears registers to defaults and all channel state to zero
// depends on spaf_pkg, spaf_divider, spaf_gain_mul and the assertion macro header
`default_nettype none
`include "synchro_phase_to_angle_filter_macros.svh"

module synchro_phase_to_angle_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [spaf_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          channel,
	input  logic [15:0]                   capture_time,
	input  logic [15:0]                   sync_time,
	input  logic [15:0]                   sync_period,
	input  logic                          set_zero,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          out_channel,
	output logic                          accepted,
	output logic signed [15:0]            filtered_angle,
	output logic signed [15:0]            scaled_value
);
	import spaf_pkg::*;

	// registers
	logic [15:0] interval_min_q;
	logic [15:0] interval_max_q;
	logic [3:0]  filter_shift_q;
	logic [15:0] gain_main_q;
	logic [15:0] gain_positive_q;
	logic [15:0] gain_negative_q;
	logic        azimuth_mode_q;
	logic        zero_cal_enable_q;

	// channel state
	logic [15:0] last_capture_q [CHANNELS];
	logic [15:0] last_sync_q    [CHANNELS];
	logic [15:0] zero_offset_q  [CHANNELS];
	logic [15:0] filter_int_q   [CHANNELS];
	logic [15:0] filter_frac_q  [CHANNELS];
	logic [15:0] scaled_hold_q  [CHANNELS];

	// item and work registers
	logic        ch_q;
	logic [15:0] cap_q;
	logic [15:0] syn_q;
	logic [15:0] per_q;
	logic        setz_q;
	logic [15:0] a_q;
	logic [15:0] sc_q;
	logic        acc_flag_q;

	// result register
	logic        result_valid_q;
	logic        out_channel_q;
	logic        accepted_q;
	logic [15:0] filtered_q;
	logic [15:0] scaled_q;

	state_t state_q, state_d;

	logic        cfg_wr;
	cfg_reg_t    cfg_idx;
	logic        ch_ok;
	logic        same_hit;
	logic [15:0] interval;
	logic        interval_bad;
	logic [15:0] phase;
	logic [15:0] phase_mag;
	logic [15:0] per_mag;
	logic        q_neg;
	logic        div_start;
	logic [15:0] div_q;
	logic [15:0] q_signed;
	div_status_t div_st;
	logic        cal_hit;
	logic [15:0] a_wrapped;
	logic [15:0] dev;
	logic [31:0] dev_ext;
	logic [4:0]  sh_amt;
	logic [31:0] acc_sum;
	logic [15:0] mul_a;
	logic [15:0] mul_g;
	logic [15:0] mul_res;
	logic        out_free;

	// apb port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = cfg_reg_t'(paddr[4:2]);

	always_comb begin
		case (cfg_idx)
			REG_INTERVAL_MIN:  prdata = {16'd0, interval_min_q};
			REG_INTERVAL_MAX:  prdata = {16'd0, interval_max_q};
			REG_FILTER_SHIFT:  prdata = {28'd0, filter_shift_q};
			REG_GAIN_MAIN:     prdata = {16'd0, gain_main_q};
			REG_GAIN_POSITIVE: prdata = {16'd0, gain_positive_q};
			REG_GAIN_NEGATIVE: prdata = {16'd0, gain_negative_q};
			REG_AZIMUTH_MODE:  prdata = {31'd0, azimuth_mode_q};
			REG_ZERO_CAL_EN:   prdata = {31'd0, zero_cal_enable_q};
			default:           prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_min_q    <= 16'd0;
			interval_max_q    <= 16'hFFFF;
			filter_shift_q    <= 4'd4;
			gain_main_q       <= 16'd256;
			gain_positive_q   <= 16'd256;
			gain_negative_q   <= 16'd256;
			azimuth_mode_q    <= 1'b0;
			zero_cal_enable_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_INTERVAL_MIN:  interval_min_q    <= pwdata[15:0];
				REG_INTERVAL_MAX:  interval_max_q    <= pwdata[15:0];
				REG_FILTER_SHIFT:  filter_shift_q    <= pwdata[3:0];
				REG_GAIN_MAIN:     gain_main_q       <= pwdata[15:0];
				REG_GAIN_POSITIVE: gain_positive_q   <= pwdata[15:0];
				REG_GAIN_NEGATIVE: gain_negative_q   <= pwdata[15:0];
				REG_AZIMUTH_MODE:  azimuth_mode_q    <= pwdata[0];
				REG_ZERO_CAL_EN:   zero_cal_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// combinational datapath
	always_comb begin
		ch_ok        = (32'(ch_q) < 32'(CHANNELS));
		same_hit     = (last_sync_q[ch_q] == syn_q) || (last_capture_q[ch_q] == cap_q);
		interval     = cap_q - last_capture_q[ch_q];
		interval_bad = (interval < interval_min_q) || (interval > interval_max_q);
		phase        = cap_q - syn_q;
		phase_mag    = phase[15] ? (16'd0 - phase) : phase;
		per_mag      = per_q[15] ? (16'd0 - per_q) : per_q;
		q_neg        = phase[15] ^ per_q[15];
		q_signed     = q_neg ? (16'd0 - div_q) : div_q;
		cal_hit      = zero_cal_enable_q && setz_q &&
			(($signed(a_q) > $signed(ONE_DEG)) || ($signed(a_q) < -$signed(ONE_DEG)));
		if (azimuth_mode_q) a_wrapped = a_q[15] ? (a_q + TURN16) : a_q;
		else a_wrapped = wrap_half(a_q);
		dev          = a_q - filter_int_q[ch_q];
		dev_ext      = {{16{dev[15]}}, dev};
		sh_amt       = 5'd16 - {1'b0, filter_shift_q};
		acc_sum      = {filter_int_q[ch_q], filter_frac_q[ch_q]} + (dev_ext << sh_amt);
		out_free     = !result_valid_q || result_ready;
		if (state_q == ST_GAIN_POL) begin
			mul_a = mul_res;
			mul_g = mul_res[15] ? gain_negative_q : gain_positive_q;
		end else begin
			mul_a = filter_int_q[ch_q];
			mul_g = gain_main_q;
		end
	end

	spaf_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({phase_mag, 15'd0}),
		.divisor  (per_mag),
		.quotient (div_q),
		.status   (div_st)
	);

	spaf_gain_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.g   (mul_g),
		.res (mul_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!ch_ok || same_hit || interval_bad) begin
					state_d = ST_DONE;
				end else if (per_q == 16'd0) begin
					state_d = ST_CAL;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV:       if (div_st.done) state_d = ST_CAL;
			ST_CAL:       state_d = cal_hit ? ST_CAL_SUB : ST_WRAP;
			ST_CAL_SUB:   state_d = ST_WRAP;
			ST_WRAP:      state_d = ST_FILTER;
			ST_FILTER:    state_d = ST_GAIN_MAIN;
			ST_GAIN_MAIN: state_d = ST_GAIN_POL;
			ST_GAIN_POL:  state_d = ST_GAIN_SEL;
			ST_GAIN_SEL:  state_d = ST_DONE;
			ST_DONE:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// channel state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_capture_q[i] <= 16'd0;
				last_sync_q[i]    <= 16'd0;
				zero_offset_q[i]  <= 16'd0;
				filter_int_q[i]   <= 16'd0;
				filter_frac_q[i]  <= 16'd0;
				scaled_hold_q[i]  <= 16'd0;
			end
		end else begin
			case (state_q)
				ST_CHECK: begin
					if (ch_ok && !same_hit) begin
						last_capture_q[ch_q] <= cap_q;
						last_sync_q[ch_q]    <= syn_q;
					end
				end
				ST_CAL: begin
					if (cal_hit) zero_offset_q[ch_q] <= wrap_half(zero_offset_q[ch_q] + a_q);
				end
				ST_FILTER: begin
					filter_int_q[ch_q]  <= acc_sum[31:16];
					filter_frac_q[ch_q] <= acc_sum[15:0];
				end
				ST_GAIN_SEL: begin
					scaled_hold_q[ch_q] <= (sc_q == 16'd0) ? 16'd0 : mul_res;
				end
				default: ;
			endcase
		end
	end

	// item and work registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					ch_q   <= channel;
					cap_q  <= capture_time;
					syn_q  <= sync_time;
					per_q  <= sync_period;
					setz_q <= set_zero;
				end
				acc_flag_q <= 1'b0;
			end
			ST_CHECK: begin
				a_q <= 16'd0 - zero_offset_q[ch_q];
			end
			ST_DIV: begin
				if (div_st.done) a_q <= q_signed - zero_offset_q[ch_q];
			end
			ST_CAL_SUB:  a_q <= a_q - zero_offset_q[ch_q];
			ST_WRAP:     a_q <= a_wrapped;
			ST_GAIN_POL: sc_q <= mul_res;
			ST_GAIN_SEL: acc_flag_q <= 1'b1;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_channel_q <= ch_q;
			accepted_q    <= acc_flag_q;
			filtered_q    <= ch_ok ? filter_int_q[ch_q] : 16'd0;
			scaled_q      <= ch_ok ? scaled_hold_q[ch_q] : 16'd0;
		end
	end

	assign result_valid   = result_valid_q;
	assign out_channel    = out_channel_q;
	assign accepted       = accepted_q;
	assign filtered_angle = filtered_q;
	assign scaled_value   = scaled_q;

	`SPAF_ASSERT(a_ready_div_idle, item_ready, !div_st.busy, "input ready while divider busy")
	`SPAF_ASSERT_NEXT(a_beat_to_check, item_valid && item_ready, state_q == ST_CHECK,
		"accepted beat did not reach check")
	`SPAF_ASSERT_NEXT(a_done_loads, (state_q == ST_DONE) && out_free,
		result_valid && (state_q == ST_IDLE), "result not loaded at done")
	`SPAF_ASSERT(a_div_in_div, div_st.busy, state_q == ST_DIV, "divider busy outside divide")

endmodule

`default_nettype wire

// ----- design/spaf_divider.sv -----
// restoring divider, one quotient bit per cycle, unsigned magnitudes
// depends on spaf_pkg and the assertion macro header
`default_nettype none
`include "synchro_phase_to_angle_filter_macros.svh"

module spaf_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [spaf_pkg::NUM_W-1:0]    dividend,
	input  logic [15:0]                   divisor,
	output logic [15:0]                   quotient,
	output spaf_pkg::div_status_t         status
);
	import spaf_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      rem_q;
	logic [NUM_W-1:0] dq_q;
	logic [15:0]      den_q;

	logic [16:0] sh;
	logic [16:0] diff;
	logic        ge;

	always_comb begin
		sh   = {rem_q, dq_q[NUM_W-1]};
		diff = sh - {1'b0, den_q};
		ge   = (sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) busy_q <= 1'b0;
				else cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : sh[15:0];
			dq_q  <= {dq_q[NUM_W-2:0], ge};
		end
	end

	assign quotient    = dq_q[15:0];
	assign status.busy = busy_q;
	assign status.done = done_q;

	`SPAF_ASSERT(a_no_restart, start, !busy_q, "divider started while busy")
	`SPAF_ASSERT_NEXT(a_done_follows, busy_q && (cnt_q == '0), done_q && !busy_q,
		"divider done missing after last step")
	`SPAF_ASSERT(a_done_idle, done_q, !busy_q, "divider done while busy")

endmodule

`default_nettype wire

// ----- design/spaf_gain_mul.sv -----
// signed 16x16 gain multiplier, keeps product bits 23..8, registered
// depends on nothing beyond its ports
`default_nettype none

module spaf_gain_mul (
	input  logic        clk,
	input  logic [15:0] a,
	input  logic [15:0] g,
	output logic [15:0] res
);
	logic signed [31:0] prod;
	logic [15:0]        res_q;

	assign prod = $signed(a) * $signed(g);

	always_ff @(posedge clk) begin
		res_q <= prod[23:8];
	end

	assign res = res_q;

endmodule

`default_nettype wire
